FILE: rtl/assert_macros.svh
// Assertion helpers of the scheduler RTL, included by dts_ctrl.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define DTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Plain invariant on the current cycle
`define DTS_CHECK(lbl, cond, msg) `DTS_ASSERT(lbl, cond, msg)

`endif

FILE: rtl/dts_pkg.sv
// Types and constants of the dependency task scheduler.
// No dependencies; imported by dts_ctrl, the scheduler top and the bench.
`timescale 1ns / 1ps

package dts_pkg;

  localparam int MaxTasks    = 64;
  localparam int TaskW       = 6;
  localparam int CntW        = 7;
  localparam int DepsW       = 8;
  localparam int PrioW       = 16;
  localparam int ModeW       = 3;
  localparam int StatW       = 3;
  // wide enough for any dependent list length in the parameter range
  localparam int NdepW       = 7;
  localparam int MaxDepsDflt = 8;
  localparam int CapReset    = 64;

  typedef enum logic [1:0] {
    PhPending = 2'd0,
    PhIssued  = 2'd1,
    PhDone    = 2'd2
  } phase_e;

  typedef enum logic [ModeW-1:0] {
    ModeAddTask  = 3'd0,
    ModeAddEdge  = 3'd1,
    ModeSetPrio  = 3'd2,
    ModeIssue    = 3'd3,
    ModeComplete = 3'd4,
    ModeClear    = 3'd5
  } mode_e;

  typedef enum logic [StatW-1:0] {
    StatOk        = 3'd0,
    StatFull      = 3'd1,
    StatNoneReady = 3'd2,
    StatBadSlot   = 3'd3,
    StatSaturated = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SEdgeB,
    SEdgeARd,
    SEdgeA,
    SPrio,
    SScan,
    SIssueWr,
    SComp,
    SDepLRd,
    SDepTRd,
    SDepTWr,
    SFinish
  } state_e;

  typedef struct packed {
    phase_e                   phase;
    logic [DepsW-1:0]         deps;
    logic signed [PrioW-1:0]  prio;
    logic [NdepW-1:0]         ndep;
  } task_rec_t;

  localparam int RecW = $bits(task_rec_t);

endpackage

FILE: rtl/dts_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read output.
// Used for the task table and the dependent lists; no package dependency.
`timescale 1ns / 1ps

module dts_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/dts_ctrl.sv
// Command sequencer of the scheduler: decodes requests, runs the read-modify-write
// passes over the task table and dependent lists. Depends on dts_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dts_ctrl
  import dts_pkg::*;
#(
  parameter int MaxDeps = MaxDepsDflt,
  localparam int LaW = $clog2(MaxTasks * MaxDeps)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [ModeW-1:0]        mode_i,
  input  logic [TaskW-1:0]        task_a_i,
  input  logic [TaskW-1:0]        task_b_i,
  input  logic signed [PrioW-1:0] priority_value_i,
  input  logic                    cfg_valid_i,
  input  logic [CntW-1:0]         cfg_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [StatW-1:0]        status_o,
  output logic [TaskW-1:0]        slot_o,
  output logic                    all_done_o,
  output logic                    t_rd_en_o,
  output logic [TaskW-1:0]        t_rd_addr_o,
  output logic                    t_wr_en_o,
  output logic [TaskW-1:0]        t_wr_addr_o,
  output task_rec_t               t_wr_rec_o,
  input  task_rec_t               t_rd_rec_i,
  output logic                    l_rd_en_o,
  output logic [LaW-1:0]          l_rd_addr_o,
  output logic                    l_wr_en_o,
  output logic [LaW-1:0]          l_wr_addr_o,
  output logic [TaskW-1:0]        l_wr_data_o,
  input  logic [TaskW-1:0]        l_rd_data_i
);

  state_e                  state_q, state_d;
  logic [CntW-1:0]         cap_q;
  logic [CntW-1:0]         total_q, total_d;
  logic [CntW-1:0]         done_q, done_d;
  logic [TaskW-1:0]        a_q, a_d, b_q, b_d;
  logic signed [PrioW-1:0] prio_q, prio_d;
  status_e                 st_q, st_d;
  logic [TaskW-1:0]        slot_q, slot_d;
  logic [CntW-1:0]         scan_q, scan_d;
  logic                    pend_q, pend_d;
  logic [TaskW-1:0]        pidx_q, pidx_d;
  logic                    found_q, found_d;
  task_rec_t               best_q, best_d;
  logic [TaskW-1:0]        pick_q, pick_d;
  logic [NdepW-1:0]        k_q, k_d, ndep_q, ndep_d;
  logic [TaskW-1:0]        dep_q, dep_d;
  logic                    out_valid_q, out_valid_d;
  status_e                 out_status_q, out_status_d;
  logic [TaskW-1:0]        out_slot_q, out_slot_d;
  logic                    out_done_q, out_done_d;

  logic            accept;
  logic            out_free;
  logic [CntW-1:0] cap_eff;
  logic            bad_a, bad_b;
  logic            scan_more;

  assign accept    = in_valid_i && (state_q == SIdle);
  assign out_free  = !out_valid_q || out_ready_i;
  assign cap_eff   = (cap_q > CntW'(MaxTasks)) ? CntW'(MaxTasks) : cap_q;
  assign bad_a     = {1'b0, task_a_i} >= total_q;
  assign bad_b     = {1'b0, task_b_i} >= total_q;
  assign scan_more = scan_q < total_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          case (mode_i)
            ModeAddEdge:  state_d = (bad_a || bad_b) ? SFinish : SEdgeB;
            ModeSetPrio:  state_d = bad_a ? SFinish : SPrio;
            ModeIssue:    state_d = SScan;
            ModeComplete: state_d = bad_a ? SFinish : SComp;
            default:      state_d = SFinish;
          endcase
        end
      end
      SEdgeB:   state_d = SEdgeARd;
      SEdgeARd: state_d = SEdgeA;
      SEdgeA:   state_d = SFinish;
      SPrio:    state_d = SFinish;
      SScan:    state_d = (!scan_more && !pend_d) ? SIssueWr : SScan;
      SIssueWr: state_d = SFinish;
      SComp:    state_d = SDepLRd;
      SDepLRd:  state_d = (k_q < ndep_q) ? SDepTRd : SFinish;
      SDepTRd:  state_d = SDepTWr;
      SDepTWr:  state_d = SDepLRd;
      SFinish:  state_d = out_free ? SIdle : SFinish;
      default:  state_d = SIdle;
    endcase
  end

  // datapath and memory control
  always_comb begin
    task_rec_t rec;
    rec          = t_rd_rec_i;
    total_d      = total_q;
    done_d       = done_q;
    a_d          = a_q;
    b_d          = b_q;
    prio_d       = prio_q;
    st_d         = st_q;
    slot_d       = slot_q;
    scan_d       = scan_q;
    pend_d       = 1'b0;
    pidx_d       = pidx_q;
    found_d      = found_q;
    best_d       = best_q;
    pick_d       = pick_q;
    k_d          = k_q;
    ndep_d       = ndep_q;
    dep_d        = dep_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_done_d   = out_done_q;
    t_rd_en_o    = 1'b0;
    t_rd_addr_o  = a_q;
    t_wr_en_o    = 1'b0;
    t_wr_addr_o  = a_q;
    t_wr_rec_o   = rec;
    l_rd_en_o    = 1'b0;
    l_wr_en_o    = 1'b0;
    l_wr_data_o  = b_q;

    case (state_q)
      SIdle: begin
        if (accept) begin
          a_d    = task_a_i;
          b_d    = task_b_i;
          prio_d = priority_value_i;
          st_d   = StatOk;
          slot_d = '0;
          case (mode_i)
            ModeAddTask: begin
              if (total_q >= cap_eff) begin
                st_d = StatFull;
              end else begin
                t_wr_en_o  = 1'b1;
                t_wr_addr_o = total_q[TaskW-1:0];
                t_wr_rec_o = '{phase: PhPending, deps: '0, prio: '0, ndep: '0};
                slot_d     = total_q[TaskW-1:0];
                total_d    = total_q + 1'b1;
              end
            end
            ModeAddEdge: begin
              if (bad_a || bad_b) begin
                st_d = StatBadSlot;
              end else begin
                t_rd_en_o   = 1'b1;
                t_rd_addr_o = task_b_i;
              end
            end
            ModeSetPrio, ModeComplete: begin
              if (bad_a) begin
                st_d = StatBadSlot;
              end else begin
                t_rd_en_o   = 1'b1;
                t_rd_addr_o = task_a_i;
              end
            end
            ModeIssue: begin
              scan_d  = '0;
              found_d = 1'b0;
            end
            ModeClear: begin
              total_d = '0;
              done_d  = '0;
            end
            default: ;
          endcase
        end
      end
      SEdgeB: begin
        // successor's counter saturates, the edge is still recorded unless the list is full
        if (rec.deps == '1) begin
          st_d = StatSaturated;
        end else begin
          rec.deps = rec.deps + 1'b1;
        end
        t_wr_en_o   = 1'b1;
        t_wr_addr_o = b_q;
        t_wr_rec_o  = rec;
      end
      SEdgeARd: begin
        t_rd_en_o = 1'b1;
      end
      SEdgeA: begin
        // full list: drop the edge
        if (rec.ndep < NdepW'(MaxDeps)) begin
          l_wr_en_o  = 1'b1;
          rec.ndep   = rec.ndep + 1'b1;
          t_wr_en_o  = 1'b1;
          t_wr_rec_o = rec;
        end
      end
      SPrio: begin
        rec.prio   = prio_q;
        t_wr_en_o  = 1'b1;
        t_wr_rec_o = rec;
      end
      SScan: begin
        if (scan_more) begin
          t_rd_en_o   = 1'b1;
          t_rd_addr_o = scan_q[TaskW-1:0];
          scan_d      = scan_q + 1'b1;
          pend_d      = 1'b1;
          pidx_d      = scan_q[TaskW-1:0];
        end
        if (pend_q && rec.phase == PhPending && rec.deps == '0 &&
            (!found_q || rec.prio > best_q.prio)) begin
          found_d = 1'b1;
          best_d  = rec;
          pick_d  = pidx_q;
        end
      end
      SIssueWr: begin
        if (found_q) begin
          t_wr_en_o        = 1'b1;
          t_wr_addr_o      = pick_q;
          t_wr_rec_o       = best_q;
          t_wr_rec_o.phase = PhIssued;
          slot_d           = pick_q;
        end else begin
          st_d = StatNoneReady;
        end
      end
      SComp: begin
        if (rec.phase != PhDone) begin
          done_d = done_q + 1'b1;
        end
        ndep_d     = rec.ndep;
        k_d        = '0;
        rec.phase  = PhDone;
        t_wr_en_o  = 1'b1;
        t_wr_rec_o = rec;
      end
      SDepLRd: begin
        l_rd_en_o = k_q < ndep_q;
      end
      SDepTRd: begin
        dep_d       = l_rd_data_i;
        t_rd_en_o   = 1'b1;
        t_rd_addr_o = l_rd_data_i;
      end
      SDepTWr: begin
        // clamp at zero on repeated completion
        if (rec.deps != '0) begin
          rec.deps = rec.deps - 1'b1;
        end
        t_wr_en_o   = 1'b1;
        t_wr_addr_o = dep_q;
        t_wr_rec_o  = rec;
        k_d         = k_q + 1'b1;
      end
      SFinish: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = st_q;
          out_slot_d   = slot_q;
          out_done_d   = done_q == total_q;
        end
      end
      default: ;
    endcase
  end

  assign l_rd_addr_o = LaW'(a_q) * LaW'(MaxDeps) + LaW'(k_q);
  assign l_wr_addr_o = LaW'(a_q) * LaW'(MaxDeps) + LaW'(t_rd_rec_i.ndep);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cap_q       <= CntW'(CapReset);
      total_q     <= '0;
      done_q      <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      total_q     <= total_d;
      done_q      <= done_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    b_q          <= b_d;
    prio_q       <= prio_d;
    st_q         <= st_d;
    slot_q       <= slot_d;
    scan_q       <= scan_d;
    pidx_q       <= pidx_d;
    best_q       <= best_d;
    pick_q       <= pick_d;
    k_q          <= k_d;
    ndep_q       <= ndep_d;
    dep_q        <= dep_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_done_q   <= out_done_d;
  end

  assign in_ready_o  = state_q == SIdle;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign slot_o      = out_slot_q;
  assign all_done_o  = out_done_q;

  `DTS_CHECK(a_done_le_total, done_q <= total_q, "done count exceeds task count")
  `DTS_CHECK(a_total_le_max, total_q <= CntW'(MaxTasks), "task count beyond table")
  `DTS_CHECK(a_no_rw_clash, !(t_rd_en_o && t_wr_en_o && t_rd_addr_o == t_wr_addr_o), "port clash")
  `DTS_ASSERT(a_accept_busy, (in_valid_i && in_ready_o) |=> !in_ready_o, "transfer while busy")

endmodule

FILE: rtl/dependency_task_scheduler_unit.sv
// Dependency task scheduler: every command gives one result carrying status, slot
// and the all-done flag. Commands run one after another through the single read and
// write port of the task table, which each step reads and writes back one entry at a
// time: issue scans every task, complete visits each recorded dependent. The next
// request is taken as soon as the result is in the output register. No clearing pass
// is needed after reset.
// Depends on dts_pkg, dts_ctrl and dts_ram.
`timescale 1ns / 1ps

module dependency_task_scheduler_unit
  import dts_pkg::*;
#(
  parameter int MaxDeps = MaxDepsDflt
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [ModeW-1:0]        mode_i,
  input  logic [TaskW-1:0]        task_a_i,
  input  logic [TaskW-1:0]        task_b_i,
  input  logic signed [PrioW-1:0] priority_value_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CntW-1:0]         cfg_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [StatW-1:0]        status_o,
  output logic [TaskW-1:0]        slot_o,
  output logic                    all_done_o
);

  localparam int LaW = $clog2(MaxTasks * MaxDeps);

  logic             t_rd_en, t_wr_en, l_rd_en, l_wr_en;
  logic [TaskW-1:0] t_rd_addr, t_wr_addr, l_wr_data, l_rd_data;
  logic [LaW-1:0]   l_rd_addr, l_wr_addr;
  task_rec_t        t_wr_rec, t_rd_rec;

  assign cfg_ready_o = 1'b1;

  dts_ctrl #(
    .MaxDeps(MaxDeps)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .mode_i,
    .task_a_i,
    .task_b_i,
    .priority_value_i,
    .cfg_valid_i,
    .cfg_data_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .slot_o,
    .all_done_o,
    .t_rd_en_o   (t_rd_en),
    .t_rd_addr_o (t_rd_addr),
    .t_wr_en_o   (t_wr_en),
    .t_wr_addr_o (t_wr_addr),
    .t_wr_rec_o  (t_wr_rec),
    .t_rd_rec_i  (t_rd_rec),
    .l_rd_en_o   (l_rd_en),
    .l_rd_addr_o (l_rd_addr),
    .l_wr_en_o   (l_wr_en),
    .l_wr_addr_o (l_wr_addr),
    .l_wr_data_o (l_wr_data),
    .l_rd_data_i (l_rd_data)
  );

  dts_ram #(
    .Width(RecW),
    .Depth(MaxTasks)
  ) u_task_ram (
    .clk_i,
    .rd_en_i   (t_rd_en),
    .rd_addr_i (t_rd_addr),
    .wr_en_i   (t_wr_en),
    .wr_addr_i (t_wr_addr),
    .wr_data_i (t_wr_rec),
    .rd_data_o (t_rd_rec)
  );

  dts_ram #(
    .Width(TaskW),
    .Depth(MaxTasks * MaxDeps)
  ) u_list_ram (
    .clk_i,
    .rd_en_i   (l_rd_en),
    .rd_addr_i (l_rd_addr),
    .wr_en_i   (l_wr_en),
    .wr_addr_i (l_wr_addr),
    .wr_data_i (l_wr_data),
    .rd_data_o (l_rd_data)
  );

endmodule

FILE: bench/dts_checker.sv
// Checker for the dependency task scheduler: watches the command, capacity and result
// channels, predicts every result from its own copy of the task table and compares.
// Depends on dts_pkg.
`timescale 1ns / 1ps

module dts_checker
  import dts_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [ModeW-1:0]        mode_i,
  input  logic [TaskW-1:0]        task_a_i,
  input  logic [TaskW-1:0]        task_b_i,
  input  logic signed [PrioW-1:0] priority_value_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CntW-1:0]         cfg_data_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [StatW-1:0]        status_i,
  input  logic [TaskW-1:0]        slot_i,
  input  logic                    all_done_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      results_o,
  output int                      saturated_o
);

  localparam int SuccSlots = MaxDepsDflt;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [TaskW-1:0] slot;
    logic             all_done;
  } sched_result_t;

  sched_result_t           result_q[$];
  int                      capacity;
  int                      task_count;
  phase_e                  phase_tab[MaxTasks];
  logic [DepsW-1:0]        wait_cnt[MaxTasks];
  logic signed [PrioW-1:0] prio_tab[MaxTasks];
  logic [TaskW-1:0]        succ_tab[MaxTasks][SuccSlots];
  int                      succ_len[MaxTasks];

  function automatic sched_result_t schedule_step(logic [ModeW-1:0] m, logic [TaskW-1:0] a,
                                                  logic [TaskW-1:0] b,
                                                  logic signed [PrioW-1:0] p);
    sched_result_t r;
    int            lim;
    bit            found;
    int            pick;
    r.status = StatOk;
    r.slot   = '0;
    found    = 1'b0;
    pick     = 0;
    lim      = (capacity > MaxTasks) ? MaxTasks : capacity;
    case (m)
      ModeAddTask: begin
        if (task_count >= lim) begin
          r.status = StatFull;
        end else begin
          r.slot                = TaskW'(task_count);
          phase_tab[task_count] = PhPending;
          wait_cnt[task_count]  = '0;
          prio_tab[task_count]  = '0;
          succ_len[task_count]  = 0;
          task_count++;
        end
      end
      ModeAddEdge: begin
        if (int'(a) >= task_count || int'(b) >= task_count) begin
          r.status = StatBadSlot;
        end else begin
          if (wait_cnt[b] == 8'hff) r.status = StatSaturated;
          else wait_cnt[b]++;
          // a full successor list drops the edge but the count above still rises
          if (succ_len[a] < SuccSlots) begin
            succ_tab[a][succ_len[a]] = b;
            succ_len[a]++;
          end
        end
      end
      ModeSetPrio: begin
        if (int'(a) >= task_count) r.status = StatBadSlot;
        else prio_tab[a] = p;
      end
      ModeIssue: begin
        for (int i = 0; i < task_count; i++) begin
          if (phase_tab[i] == PhPending && wait_cnt[i] == 0 &&
              (!found || prio_tab[i] > prio_tab[pick])) begin
            found = 1'b1;
            pick  = i;
          end
        end
        if (found) begin
          phase_tab[pick] = PhIssued;
          r.slot          = TaskW'(pick);
        end else begin
          r.status = StatNoneReady;
        end
      end
      ModeComplete: begin
        if (int'(a) >= task_count) begin
          r.status = StatBadSlot;
        end else begin
          phase_tab[a] = PhDone;
          for (int i = 0; i < succ_len[a]; i++)
            if (wait_cnt[succ_tab[a][i]] > 0) wait_cnt[succ_tab[a][i]]--;
        end
      end
      ModeClear: task_count = 0;
      default: ;
    endcase
    r.all_done = 1'b1;
    for (int i = 0; i < task_count; i++)
      if (phase_tab[i] != PhDone) r.all_done = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t want;
    if (!rst_ni) begin
      capacity     = CapReset;
      task_count   = 0;
      result_q.delete();
      fail_count_o = 0;
      results_o    = 0;
      saturated_o  = 0;
      pending_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) capacity = int'(cfg_data_i);
      // retire before predicting: a result never belongs to a command taken on the same edge
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $error("result transfer with nothing expected: status %0d slot %0d all_done %0d",
                 status_i, slot_i, all_done_i);
          fail_count_o++;
        end else begin
          want = result_q.pop_front();
          results_o++;
          if (want.status == StatSaturated) saturated_o++;
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fail_count_o++;
          end
          if (slot_i !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, slot_i);
            fail_count_o++;
          end
          if (all_done_i !== want.all_done) begin
            $error("all_done: expected %0d, got %0d", want.all_done, all_done_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        result_q.push_back(schedule_step(mode_i, task_a_i, task_b_i, priority_value_i));
      pending_o <= result_q.size();
    end
  end

endmodule

FILE: bench/testbench.sv
// Top of the scheduler testbench: clock, reset, command and capacity stimulus, verdict.
// Depends on dts_pkg, dependency_task_scheduler_unit and dts_checker.
`timescale 1ns / 1ps

module testbench;
  import dts_pkg::*;

  localparam int CycleLimit = 800000;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid;
  logic                    in_ready;
  logic [ModeW-1:0]        mode;
  logic [TaskW-1:0]        task_a;
  logic [TaskW-1:0]        task_b;
  logic signed [PrioW-1:0] prio;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CntW-1:0]         cfg_data;
  logic                    out_valid;
  logic                    out_ready;
  logic [StatW-1:0]        status;
  logic [TaskW-1:0]        slot;
  logic                    all_done;

  int fail_count, pending, results, saturated;
  int cmds_sent, cap_writes, cycles, cur_cap;
  bit calm, hold_req;

  dependency_task_scheduler_unit dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .mode_i(mode), .task_a_i(task_a), .task_b_i(task_b), .priority_value_i(prio),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .slot_o(slot), .all_done_o(all_done)
  );

  dts_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .mode_i(mode), .task_a_i(task_a), .task_b_i(task_b), .priority_value_i(prio),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .status_i(status), .slot_i(slot), .all_done_i(all_done),
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results),
    .saturated_o(saturated)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // result side: random back-pressure, or one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 22);
      end
    end
  end

  task automatic send_cmd(logic [ModeW-1:0] m, logic [TaskW-1:0] a, logic [TaskW-1:0] b,
                          logic signed [PrioW-1:0] p);
    if (!calm && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    mode     <= m;
    task_a   <= a;
    task_b   <= b;
    prio     <= p;
    do @(posedge clk_i); while (!in_ready);
    cmds_sent++;
  endtask

  task automatic send_noise();
    send_cmd(ModeW'($urandom_range(0, 7)), TaskW'($urandom), TaskW'($urandom),
             PrioW'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CntW-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_cap = int'(v);
    cap_writes++;
  endtask

  // one schedule: clear, fill, wire up a mostly forward graph, prioritise, then run it
  task automatic run_schedule(int n_max);
    int n, lo, hi, next_done;
    n = $urandom_range(1, n_max);
    send_cmd(ModeClear, TaskW'($urandom), TaskW'($urandom), PrioW'($urandom));
    repeat (n + $urandom_range(0, 2))
      send_cmd(ModeAddTask, TaskW'($urandom), TaskW'($urandom), PrioW'($urandom));
    repeat ($urandom_range(0, 2 * n)) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        lo = $urandom_range(0, n - 1);
        hi = (lo < n - 1) ? $urandom_range(lo + 1, n - 1) : lo;
        send_cmd(ModeAddEdge, TaskW'(lo), TaskW'(hi), PrioW'($urandom));
      end
    end
    repeat ($urandom_range(0, n)) begin
      case ($urandom_range(0, 5))
        0:       send_cmd(ModeSetPrio, TaskW'($urandom_range(0, n - 1)), TaskW'($urandom),
                          16'sh7fff);
        1:       send_cmd(ModeSetPrio, TaskW'($urandom_range(0, n - 1)), TaskW'($urandom),
                          16'sh8000);
        2:       send_cmd(ModeSetPrio, TaskW'($urandom_range(0, n - 1)), TaskW'($urandom),
                          PrioW'($urandom_range(0, 3)));
        default: send_cmd(ModeSetPrio, TaskW'($urandom_range(0, n - 1)), TaskW'($urandom),
                          PrioW'($urandom));
      endcase
    end
    next_done = 0;
    while (next_done < n) begin
      case ($urandom_range(0, 9))
        0:       send_noise();
        1, 2, 3: send_cmd(ModeIssue, TaskW'($urandom), TaskW'($urandom), PrioW'($urandom));
        default: begin
          send_cmd(ModeComplete, TaskW'(next_done), TaskW'($urandom), PrioW'($urandom));
          next_done++;
        end
      endcase
    end
    send_cmd(ModeIssue, TaskW'($urandom), TaskW'($urandom), PrioW'($urandom));
  endtask

  initial begin
    logic [CntW-1:0] caps[8];
    int n_max;
    caps = '{7'd0, 7'd1, 7'd2, 7'd127, 7'd64, 7'd5, 7'd33, 7'd16};
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    mode      = '0;
    task_a    = '0;
    task_b    = '0;
    prio      = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    cmds_sent = 0;
    cap_writes = 0;
    cur_cap   = CapReset;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, unused modes, extremes, self edge, completion in any phase
    send_cmd(ModeIssue, 6'd0, 6'd0, 16'sd0);
    send_cmd(ModeComplete, 6'd0, 6'd0, 16'sd0);
    send_cmd(3'd6, 6'd63, 6'd63, 16'sh7fff);
    send_cmd(3'd7, 6'd0, 6'd0, 16'sh8000);
    repeat (4) send_cmd(ModeAddTask, 6'd0, 6'd0, 16'sd0);
    send_cmd(ModeSetPrio, 6'd1, 6'd0, 16'sh7fff);
    send_cmd(ModeSetPrio, 6'd2, 6'd0, 16'sh8000);
    send_cmd(ModeSetPrio, 6'd63, 6'd0, 16'sd5);
    send_cmd(ModeAddEdge, 6'd0, 6'd0, 16'sd0);
    send_cmd(ModeAddEdge, 6'd1, 6'd2, 16'sd0);
    send_cmd(ModeAddEdge, 6'd63, 6'd1, 16'sd0);
    send_cmd(ModeAddEdge, 6'd1, 6'd63, 16'sd0);
    send_cmd(ModeIssue, 6'd0, 6'd0, 16'sd0);
    send_cmd(ModeIssue, 6'd0, 6'd0, 16'sd0);
    send_cmd(ModeComplete, 6'd1, 6'd0, 16'sd0);
    send_cmd(ModeIssue, 6'd0, 6'd0, 16'sd0);
    send_cmd(ModeIssue, 6'd0, 6'd0, 16'sd0);
    send_cmd(ModeComplete, 6'd0, 6'd0, 16'sd0);
    send_cmd(ModeComplete, 6'd0, 6'd0, 16'sd0);
    send_cmd(ModeComplete, 6'd2, 6'd0, 16'sd0);
    send_cmd(ModeComplete, 6'd3, 6'd0, 16'sd0);
    send_cmd(ModeClear, 6'd0, 6'd0, 16'sd0);

    // saturate one counter and overflow a successor list
    send_cmd(ModeAddTask, 6'd0, 6'd0, 16'sd0);
    send_cmd(ModeAddTask, 6'd0, 6'd0, 16'sd0);
    repeat (258) send_cmd(ModeAddEdge, 6'd0, 6'd1, PrioW'($urandom));
    send_cmd(ModeComplete, 6'd0, 6'd0, 16'sd0);
    send_cmd(ModeIssue, 6'd0, 6'd0, 16'sd0);

    for (int ph = 0; ph < 8; ph++) begin
      write_capacity(caps[ph]);
      calm = (ph == 4);
      if (ph == 5) hold_req = 1'b1;
      while (cmds_sent < 400 + ph * 85) begin
        n_max = (cur_cap > 12) ? 12 : ((cur_cap < 1) ? 3 : cur_cap);
        if (cur_cap >= 64 && $urandom_range(0, 7) == 0) n_max = 64;
        run_schedule(n_max);
      end
    end
    calm = 1'b0;
    drain();
    repeat (20) @(posedge clk_i);

    $display("%0d commands over %0d capacity settings, %0d results checked",
             cmds_sent, cap_writes + 1, results);
    $display("%0d saturated edges, long result hold-off and idle-free phase included",
             saturated);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
